// ===== design/pointer_register_address_unit_core_assert.svh =====
// Assertion macros for the pointer register address unit.
// Used by the checker that binds to the top level; no other dependencies.
`ifndef POINTER_REGISTER_ADDRESS_UNIT_CORE_ASSERT_SVH
`define POINTER_REGISTER_ADDRESS_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define PRUC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pointer register unit: same-cycle check failed");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define PRUC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pointer register unit: next-cycle check failed");

`endif

// ===== design/pruc_pkg.sv =====
// Shared types, command codes and helper functions for the pointer register unit.
// No dependencies; imported by the controller, the datapath and the top level.
package pruc_pkg;

  // Command codes of the request.
  localparam logic [2:0] CMD_XCHG  = 3'd0;
  localparam logic [2:0] CMD_COPY  = 3'd1;
  localparam logic [2:0] CMD_ADD   = 3'd2;
  localparam logic [2:0] CMD_LOAD  = 3'd3;
  localparam logic [2:0] CMD_LOGIC = 3'd4;
  localparam logic [2:0] CMD_GEN   = 3'd5;

  // Upper half that marks a logical address.
  localparam logic [31:0] LOGICAL_MASK = 32'hffff_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // a request is taken this cycle
    logic step;    // emit the next byte of a running address run
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_multi;  // the request on the inputs is a run of two or more bytes
    logic run_end;    // the byte emitted by this step is the last of the run
  } dp_status_t;

  // Sign-extend the offset from 16 bits, or from its low 8 bits when short.
  function automatic logic [31:0] sext_offset(input logic [15:0] offs,
                                              input logic is_short);
    logic [31:0] v;
    if (is_short) begin
      v = {{24{offs[7]}}, offs[7:0]};
    end else begin
      v = {{16{offs[15]}}, offs};
    end
    return v;
  endfunction

  // Add that keeps the upper half all ones when the base is logical.
  function automatic logic [31:0] add_keep_logical(input logic [31:0] base,
                                                   input logic [31:0] delta);
    logic [31:0] sum;
    sum = base + delta;
    if ((base & LOGICAL_MASK) == LOGICAL_MASK) begin
      sum = sum | LOGICAL_MASK;
    end
    return sum;
  endfunction

  // Index of the last byte of a run: zero counts as one, above four saturates.
  function automatic logic [1:0] run_last_index(input logic [2:0] cnt);
    logic [1:0] li;
    case (cnt) inside
      3'd0:          li = 2'd0;
      [3'd1:3'd4]:   li = 2'(cnt - 3'd1);
      default:       li = 2'd3;
    endcase
    return li;
  endfunction

endpackage

// ===== design/pruc_ctrl.sv =====
// Controller state machine of the pointer register unit.
// Depends on pruc_pkg for the command and status structs.
module pruc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  pruc_pkg::dp_status_t status,
  output logic                 busy,
  output pruc_pkg::ctrl_cmd_t  cmd
);
  import pruc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;

  // Requests are refused only while an address run is still emitting bytes.
  assign busy       = (state_r == ST_RUN);
  assign cmd.accept = start && !busy;
  assign cmd.step   = (state_r == ST_RUN);

  // Enter the run state on a multi-byte run, leave it after its last byte.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && status.run_multi) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.run_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/pruc_dp.sv =====
// Datapath of the pointer register unit: both register banks, the offset adder,
// the run counter and the result register. Depends on pruc_pkg.
module pruc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pruc_pkg::ctrl_cmd_t  cmd,
  output pruc_pkg::dp_status_t status,
  input  logic [2:0]           in_cmd,
  input  logic [1:0]           in_dst_sel,
  input  logic [1:0]           in_src_sel,
  input  logic                 in_alt_dest,
  input  logic [15:0]          in_offset,
  input  logic                 in_offset_short,
  input  logic [31:0]          in_load_value,
  input  logic [2:0]           in_byte_count,
  output logic                 out_valid,
  output logic [31:0]          out_reg_value,
  output logic [31:0]          out_address,
  output logic [7:0]           out_data_byte,
  output logic [1:0]           out_byte_index,
  output logic                 out_last
);
  import pruc_pkg::*;

  // Register banks; both reset to zero.
  logic [31:0] main_r [4];
  logic [31:0] alt_r  [4];
  logic [31:0] main_nxt [4];
  logic [31:0] alt_nxt  [4];

  // Run state of an address generation.
  logic [31:0] base_r, base_nxt;
  logic [31:0] src_val_r, src_val_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  last_idx_r, last_idx_nxt;

  // Result register.
  logic        valid_r, valid_nxt;
  logic [31:0] reg_value_r, reg_value_nxt;
  logic [31:0] address_r, address_nxt;
  logic [7:0]  data_byte_r, data_byte_nxt;
  logic [1:0]  byte_index_r, byte_index_nxt;
  logic        last_r, last_nxt;

  logic [31:0] src_val;
  logic [31:0] sum;
  logic [1:0]  in_last_idx;
  logic        wr_en;
  logic [31:0] wr_val;

  assign src_val     = main_r[in_src_sel];
  assign sum         = add_keep_logical(src_val, sext_offset(in_offset, in_offset_short));
  assign in_last_idx = run_last_index(in_byte_count);

  assign status.run_multi = (in_cmd == CMD_GEN) && (in_last_idx != 2'd0);
  assign status.run_end   = (idx_r == last_idx_r);

  // Value written to the destination register by the single-result commands.
  always_comb begin
    wr_en  = 1'b0;
    wr_val = src_val;
    case (in_cmd)
      CMD_COPY:  begin wr_en = 1'b1; wr_val = src_val; end
      CMD_ADD:   begin wr_en = 1'b1; wr_val = sum; end
      CMD_LOAD:  begin wr_en = 1'b1; wr_val = in_load_value; end
      CMD_LOGIC: begin wr_en = 1'b1; wr_val = LOGICAL_MASK | {16'h0000, in_load_value[15:0]}; end
      default:   begin wr_en = 1'b0; wr_val = src_val; end
    endcase
  end

  // Next state of the banks, the run and the result register.
  always_comb begin
    main_nxt       = main_r;
    alt_nxt        = alt_r;
    base_nxt       = base_r;
    src_val_nxt    = src_val_r;
    idx_nxt        = idx_r;
    last_idx_nxt   = last_idx_r;
    valid_nxt      = 1'b0;
    reg_value_nxt  = reg_value_r;
    address_nxt    = address_r;
    data_byte_nxt  = data_byte_r;
    byte_index_nxt = byte_index_r;
    last_nxt       = last_r;

    if (cmd.step) begin
      // Next byte of a running address run.
      valid_nxt      = 1'b1;
      reg_value_nxt  = src_val_r;
      address_nxt    = add_keep_logical(base_r, {30'd0, idx_r});
      data_byte_nxt  = src_val_r[{idx_r, 3'b000} +: 8];
      byte_index_nxt = idx_r;
      last_nxt       = (idx_r == last_idx_r);
      idx_nxt        = idx_r + 2'd1;
    end else if (cmd.accept) begin
      address_nxt    = 32'd0;
      data_byte_nxt  = 8'd0;
      byte_index_nxt = 2'd0;
      last_nxt       = 1'b1;
      case (in_cmd)
        CMD_XCHG: begin
          main_nxt      = alt_r;
          alt_nxt       = main_r;
          valid_nxt     = 1'b1;
          reg_value_nxt = alt_r[in_dst_sel];
        end
        CMD_COPY, CMD_ADD, CMD_LOAD, CMD_LOGIC: begin
          valid_nxt     = 1'b1;
          reg_value_nxt = wr_val;
        end
        CMD_GEN: begin
          // First byte goes out now; the rest follow in the run state.
          valid_nxt     = 1'b1;
          reg_value_nxt = src_val;
          address_nxt   = sum;
          data_byte_nxt = src_val[7:0];
          last_nxt      = (in_last_idx == 2'd0);
          base_nxt      = sum;
          src_val_nxt   = src_val;
          idx_nxt       = 2'd1;
          last_idx_nxt  = in_last_idx;
        end
        default: valid_nxt = 1'b0;
      endcase
      if (wr_en) begin
        if (in_alt_dest) begin
          alt_nxt[in_dst_sel] = wr_val;
        end else begin
          main_nxt[in_dst_sel] = wr_val;
        end
      end
    end
  end

  // Control state and banks take reset; payload registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        main_r[i] <= 32'd0;
        alt_r[i]  <= 32'd0;
      end
      valid_r <= 1'b0;
    end else begin
      main_r  <= main_nxt;
      alt_r   <= alt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    src_val_r    <= src_val_nxt;
    idx_r        <= idx_nxt;
    last_idx_r   <= last_idx_nxt;
    reg_value_r  <= reg_value_nxt;
    address_r    <= address_nxt;
    data_byte_r  <= data_byte_nxt;
    byte_index_r <= byte_index_nxt;
    last_r       <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_reg_value  = reg_value_r;
  assign out_address    = address_r;
  assign out_data_byte  = data_byte_r;
  assign out_byte_index = byte_index_r;
  assign out_last       = last_r;

endmodule

// ===== design/pointer_register_address_unit_core.sv =====
// Pointer register address unit: four pointer registers with alternate copies.
// A single result, or the first byte of an address run, is registered and appears in
// the cycle after its request is taken; the run counter emits the rest one per cycle.
// One request per cycle while busy is low; busy stays high while a run's later bytes go out.
// Reset (rst_n low, synchronous) clears both banks to zero and drops busy and out_valid.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
module pointer_register_address_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [1:0]  in_dst_sel,
  input  logic [1:0]  in_src_sel,
  input  logic        in_alt_dest,
  input  logic [15:0] in_offset,
  input  logic        in_offset_short,
  input  logic [31:0] in_load_value,
  input  logic [2:0]  in_byte_count,
  output logic        out_valid,
  output logic [31:0] out_reg_value,
  output logic [31:0] out_address,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_byte_index,
  output logic        out_last
);
  import pruc_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // Sequencer for requests and address runs.
  pruc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (dp_status),
    .busy   (busy),
    .cmd    (ctrl_cmd)
  );

  // Register banks, adder and result register.
  pruc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctrl_cmd),
    .status          (dp_status),
    .in_cmd          (in_cmd),
    .in_dst_sel      (in_dst_sel),
    .in_src_sel      (in_src_sel),
    .in_alt_dest     (in_alt_dest),
    .in_offset       (in_offset),
    .in_offset_short (in_offset_short),
    .in_load_value   (in_load_value),
    .in_byte_count   (in_byte_count),
    .out_valid       (out_valid),
    .out_reg_value   (out_reg_value),
    .out_address     (out_address),
    .out_data_byte   (out_data_byte),
    .out_byte_index  (out_byte_index),
    .out_last        (out_last)
  );

endmodule

// ===== design/pruc_checker.sv =====
// Port-level checker for the pointer register unit, bound to the top level.
// Depends on pruc_pkg and the assertion macro header.
`include "pointer_register_address_unit_core_assert.svh"

module pruc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_cmd,
  input logic [2:0]  in_byte_count,
  input logic [31:0] in_load_value,
  input logic        out_valid,
  input logic [31:0] out_reg_value,
  input logic [1:0]  out_byte_index,
  input logic        out_last
);
  import pruc_pkg::*;

  // A run that has not ended keeps emitting in the next cycle.
  `PRUC_ASSERT_NXT(a_run_continues, out_valid && !out_last, out_valid)

  // While a run is unfinished the unit refuses requests.
  `PRUC_ASSERT_IMP(a_busy_in_run, out_valid && !out_last, busy)

  // Bytes of a run come out in ascending order.
  `PRUC_ASSERT_NXT(a_index_steps, out_valid && !out_last,
                   out_byte_index == $past(out_byte_index) + 2'd1)

  // A multi-byte run starts with byte zero and is not yet finished.
  `PRUC_ASSERT_NXT(a_run_start, start && !busy && in_cmd == CMD_GEN && in_byte_count > 3'd1,
                   out_valid && !out_last && out_byte_index == 2'd0)

  // A load returns the loaded value as a single result.
  `PRUC_ASSERT_NXT(a_load_result, start && !busy && in_cmd == CMD_LOAD,
                   out_valid && out_last && out_reg_value == $past(in_load_value))

endmodule

bind pointer_register_address_unit_core pruc_checker u_pruc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_cmd         (in_cmd),
  .in_byte_count  (in_byte_count),
  .in_load_value  (in_load_value),
  .out_valid      (out_valid),
  .out_reg_value  (out_reg_value),
  .out_byte_index (out_byte_index),
  .out_last       (out_last)
);

// ===== test/pointer_register_address_unit_core_test.sv =====
// Self-checking testbench for the pointer register address unit.
// Needs pruc_pkg and pointer_register_address_unit_core; predicts every result
// from its own model of both register banks and checks each output strobe.
`timescale 1ns / 100ps

module pointer_register_address_unit_core_test;
  import pruc_pkg::*;

  // Command codes that the block must ignore.
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int LIMIT_CYCLES = 40000;
  localparam int RANDOM_REQS  = 88;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [2:0]  cmd;
    logic [1:0]  dst_sel;
    logic [1:0]  src_sel;
    logic        alt_dest;
    logic [15:0] offset;
    logic        offset_short;
    logic [31:0] load_value;
    logic [2:0]  byte_count;
  } ptr_req_t;

  typedef struct {
    logic [31:0] reg_value;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [1:0]  byte_index;
    logic        last;
  } ptr_res_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [1:0]  in_dst_sel;
  logic [1:0]  in_src_sel;
  logic        in_alt_dest;
  logic [15:0] in_offset;
  logic        in_offset_short;
  logic [31:0] in_load_value;
  logic [2:0]  in_byte_count;
  logic        out_valid;
  logic [31:0] out_reg_value;
  logic [31:0] out_address;
  logic [7:0]  out_data_byte;
  logic [1:0]  out_byte_index;
  logic        out_last;

  // Model of the two pointer banks and the results still to come out.
  logic [31:0] ptr_main [4];
  logic [31:0] ptr_alt [4];
  ptr_res_t    ptr_results_due [$];
  int          fails;
  int          cycle_count;
  bit          no_idle;

  pointer_register_address_unit_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_dst_sel      (in_dst_sel),
    .in_src_sel      (in_src_sel),
    .in_alt_dest     (in_alt_dest),
    .in_offset       (in_offset),
    .in_offset_short (in_offset_short),
    .in_load_value   (in_load_value),
    .in_byte_count   (in_byte_count),
    .out_valid       (out_valid),
    .out_reg_value   (out_reg_value),
    .out_address     (out_address),
    .out_data_byte   (out_data_byte),
    .out_byte_index  (out_byte_index),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Sign-extend the offset from bit 15, or from bit 7 for a short offset.
  function automatic logic [31:0] widen_offset(logic [15:0] offs, logic is_short);
    if (is_short) begin
      return {{24{offs[7]}}, offs[7:0]};
    end
    return {{16{offs[15]}}, offs};
  endfunction

  // A logical base keeps its upper half all ones through the add.
  function automatic logic [31:0] pointer_sum(logic [31:0] base, logic [31:0] delta);
    logic [31:0] sum;
    sum = base + delta;
    if (base[31:16] == 16'hffff) begin
      sum[31:16] = 16'hffff;
    end
    return sum;
  endfunction

  // Update the bank model for one accepted request and queue its results.
  task automatic apply_ptr_command(input ptr_req_t r);
    logic [31:0] v;
    logic [31:0] base;
    logic [31:0] tmp;
    ptr_res_t    res;
    int          n;
    bit          writes;
    writes = 1'b1;
    v = '0;
    res.address = '0;
    res.data_byte = '0;
    res.byte_index = '0;
    res.last = 1'b1;
    case (r.cmd)
      CMD_XCHG: begin
        for (int i = 0; i < 4; i++) begin
          tmp = ptr_main[i];
          ptr_main[i] = ptr_alt[i];
          ptr_alt[i] = tmp;
        end
        writes = 1'b0;
        res.reg_value = ptr_main[r.dst_sel];
        ptr_results_due.push_back(res);
      end
      CMD_COPY:  v = ptr_main[r.src_sel];
      CMD_ADD:   v = pointer_sum(ptr_main[r.src_sel],
                                 widen_offset(r.offset, r.offset_short));
      CMD_LOAD:  v = r.load_value;
      CMD_LOGIC: v = {16'hffff, r.load_value[15:0]};
      CMD_GEN: begin
        writes = 1'b0;
        n = (r.byte_count == 3'd0) ? 1 : (r.byte_count > 3'd4) ? 4 : int'(r.byte_count);
        base = pointer_sum(ptr_main[r.src_sel], widen_offset(r.offset, r.offset_short));
        for (int i = 0; i < n; i++) begin
          res.reg_value = ptr_main[r.src_sel];
          res.address = pointer_sum(base, 32'(i));
          res.data_byte = ptr_main[r.src_sel][8*i +: 8];
          res.byte_index = 2'(i);
          res.last = (i == n - 1);
          ptr_results_due.push_back(res);
        end
      end
      default: writes = 1'b0;
    endcase
    if (writes) begin
      if (r.alt_dest) begin
        ptr_alt[r.dst_sel] = v;
      end else begin
        ptr_main[r.dst_sel] = v;
      end
      res.reg_value = v;
      ptr_results_due.push_back(res);
    end
  endtask

  function automatic ptr_req_t make_req(logic [2:0] cmd, logic [1:0] dst, logic [1:0] src,
                                        logic alt, logic [15:0] offs, logic is_short,
                                        logic [31:0] lv, logic [2:0] cnt);
    ptr_req_t r;
    r.cmd = cmd;
    r.dst_sel = dst;
    r.src_sel = src;
    r.alt_dest = alt;
    r.offset = offs;
    r.offset_short = is_short;
    r.load_value = lv;
    r.byte_count = cnt;
    return r;
  endfunction

  // Drive one request after a random gap (none while no_idle is set) and hold it until the block takes it.
  task automatic send_req(input ptr_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd = r.cmd;
    in_dst_sel = r.dst_sel;
    in_src_sel = r.src_sel;
    in_alt_dest = r.alt_dest;
    in_offset = r.offset;
    in_offset_short = r.offset_short;
    in_load_value = r.load_value;
    in_byte_count = r.byte_count;
    start = 1'b1;
    do @(posedge clk); while (busy);
    apply_ptr_command(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  // Compare every result strobe with the oldest outstanding expectation.
  always @(posedge clk) begin
    ptr_res_t want;
    if (rst_n && out_valid) begin
      if (ptr_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual reg_value %h address %h",
                 $time, out_reg_value, out_address);
        fails++;
      end else begin
        want = ptr_results_due.pop_front();
        check_field("reg_value", want.reg_value, out_reg_value);
        check_field("address", want.address, out_address);
        check_field("data_byte", 32'(want.data_byte), 32'(out_data_byte));
        check_field("byte_index", 32'(want.byte_index), 32'(out_byte_index));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[pointer_register_address_unit_core] ERROR");
      $finish;
    end
  end

  // Full-width and logical loads into both banks.
  task automatic test_loads();
    send_req(make_req(CMD_LOAD, 2'd0, 2'd0, 1'b0, 16'h0000, 1'b0, 32'hffff_ffff, 3'd0));
    send_req(make_req(CMD_LOAD, 2'd1, 2'd2, 1'b1, 16'hffff, 1'b1, 32'h1234_5678, 3'd7));
    send_req(make_req(CMD_LOGIC, 2'd2, 2'd0, 1'b0, 16'h0000, 1'b0, 32'habcd_8000, 3'd0));
    send_req(make_req(CMD_LOAD, 2'd3, 2'd0, 1'b0, 16'h0000, 1'b0, 32'h0000_0005, 3'd0));
    send_req(make_req(CMD_LOGIC, 2'd3, 2'd1, 1'b1, 16'h0000, 1'b0, 32'h0000_ffff, 3'd0));
  endtask

  // Swap the banks and swap them back.
  task automatic test_exchange();
    send_req(make_req(CMD_XCHG, 2'd1, 2'd0, 1'b0, 16'h0000, 1'b0, 32'h0, 3'd0));
    send_req(make_req(CMD_XCHG, 2'd3, 2'd2, 1'b1, 16'hffff, 1'b1, 32'hffff_ffff, 3'd7));
  endtask

  // Copy, long and short offsets, wraparound and the logical rule.
  task automatic test_copy_add();
    send_req(make_req(CMD_COPY, 2'd1, 2'd0, 1'b1, 16'h0000, 1'b0, 32'h0, 3'd0));
    send_req(make_req(CMD_ADD, 2'd1, 2'd3, 1'b0, 16'h8000, 1'b0, 32'h0, 3'd0));
    send_req(make_req(CMD_ADD, 2'd2, 2'd0, 1'b0, 16'h0001, 1'b1, 32'h0, 3'd0));
    send_req(make_req(CMD_ADD, 2'd0, 2'd3, 1'b0, 16'h1280, 1'b1, 32'h0, 3'd0));
    send_req(make_req(CMD_ADD, 2'd3, 2'd3, 1'b0, 16'h7fff, 1'b0, 32'h0, 3'd0));
  endtask

  // Address runs of every length, with zero and oversized byte counts.
  task automatic test_generate();
    no_idle = 1'b1;
    send_req(make_req(CMD_GEN, 2'd0, 2'd0, 1'b0, 16'h007a, 1'b1, 32'h0, 3'd4));
    send_req(make_req(CMD_GEN, 2'd3, 2'd1, 1'b1, 16'h0000, 1'b0, 32'h0, 3'd0));
    no_idle = 1'b0;
    send_req(make_req(CMD_GEN, 2'd0, 2'd2, 1'b0, 16'hffff, 1'b0, 32'h0, 3'd7));
    send_req(make_req(CMD_GEN, 2'd2, 2'd3, 1'b1, 16'h00ff, 1'b1, 32'h0, 3'd5));
    send_req(make_req(CMD_GEN, 2'd1, 2'd3, 1'b0, 16'h0100, 1'b0, 32'h0, 3'd2));
    send_req(make_req(CMD_GEN, 2'd0, 2'd1, 1'b1, 16'h0002, 1'b1, 32'h0, 3'd3));
    send_req(make_req(CMD_GEN, 2'd0, 2'd1, 1'b0, 16'h0000, 1'b0, 32'h0, 3'd1));
  endtask

  // Unused codes must leave the banks alone and return nothing.
  task automatic test_unused_cmds();
    send_req(make_req(CMD_RSVD6, 2'd0, 2'd1, 1'b0, 16'h1234, 1'b0, 32'hdead_beef, 3'd2));
    send_req(make_req(CMD_RSVD7, 2'd1, 2'd2, 1'b1, 16'h8080, 1'b1, 32'h0bad_f00d, 3'd4));
    send_req(make_req(CMD_COPY, 2'd2, 2'd0, 1'b0, 16'h0000, 1'b0, 32'h0, 3'd0));
  endtask

  // Random mix, weighted toward loads of interesting values and address runs.
  task automatic test_random_mix();
    ptr_req_t r;
    int       pick;
    for (int k = 0; k < RANDOM_REQS; k++) begin
      if (k % 16 == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      r.dst_sel = 2'($urandom_range(0, 3));
      r.src_sel = 2'($urandom_range(0, 3));
      r.alt_dest = 1'($urandom_range(0, 1));
      r.offset_short = 1'($urandom_range(0, 1));
      r.offset = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) - 16'd1
                                             : 16'($urandom);
      case ($urandom_range(0, 3))
        0:       r.load_value = $urandom;
        1:       r.load_value = {16'hffff, 16'($urandom)};
        2:       r.load_value = 32'hfffe_ff00 + 32'($urandom_range(0, 511));
        default: r.load_value = 32'($urandom_range(0, 300));
      endcase
      r.byte_count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 4));
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        r.cmd = CMD_LOAD;
      end else if (pick < 22) begin
        r.cmd = CMD_LOGIC;
      end else if (pick < 30) begin
        r.cmd = CMD_XCHG;
      end else if (pick < 40) begin
        r.cmd = CMD_COPY;
      end else if (pick < 60) begin
        r.cmd = CMD_ADD;
      end else if (pick < 94) begin
        r.cmd = CMD_GEN;
      end else begin
        r.cmd = (pick < 97) ? CMD_RSVD6 : CMD_RSVD7;
      end
      send_req(r);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    fails = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ptr_main[i] = '0;
      ptr_alt[i] = '0;
    end
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_XCHG;
    in_dst_sel = '0;
    in_src_sel = '0;
    in_alt_dest = 1'b0;
    in_offset = '0;
    in_offset_short = 1'b0;
    in_load_value = '0;
    in_byte_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_loads();
    test_exchange();
    test_copy_add();
    test_generate();
    test_unused_cmds();
    test_random_mix();

    // Release the request line, drain the results and watch for strays.
    @(negedge clk);
    start = 1'b0;
    while (ptr_results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("[pointer_register_address_unit_core] OK");
    end else begin
      $display("[pointer_register_address_unit_core] ERROR");
    end
    $finish;
  end

endmodule
